FILE: sv/lksc_pkg.sv
// lksc_pkg: shared types, op codes and default sizes for the keyed slot cache
// no dependencies
`timescale 1ns / 1ps
package lksc_pkg;

    localparam int DEF_SLOTS  = 16;
    localparam int DEF_PREFIX = 32;
    localparam int DEF_TICK_W = 48;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = 32;

    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_CLAIM    = 2'd1;
    localparam logic [1:0] OP_REGISTER = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        key;
        logic [7:0]         slot;
        logic signed [31:0] token;
        logic               has_token;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [3:0]       slot_index;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] eviction_count;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic wr_key;
        logic wr_tick;
        logic wr_plen;
    } t_cell_ctl;

endpackage

FILE: sv/lru_keyed_slot_cache.sv
// lru_keyed_slot_cache: top level, sequencer, counters and prefix memory
// uses lksc_pkg and lksc_cell
//
// channel  dir  handshake            word
// input    in   i_valid / o_ready    t_in_word
// output   out  o_valid / i_ready    t_out_word
// config   in   i_cfg_we             i_cfg_wdata
//
// lookup that opens a stream: the key runs through the registered search
// chain, one cell a cycle, then the token step; claim: the search chain only
// a token read in lookup adds the S_READ state for the prefix memory read
// clear gives its result in the cycle after it is taken; other items skip the search
// a new word is taken only once the previous result has been taken
// reset is synchronous and needs no clearing pass
`timescale 1ns / 1ps
module lru_keyed_slot_cache #(
    parameter int SLOTS         = lksc_pkg::DEF_SLOTS,
    parameter int PREFIX_LEN    = lksc_pkg::DEF_PREFIX,
    parameter int TICK_WIDTH    = lksc_pkg::DEF_TICK_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  lksc_pkg::t_in_word               i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output lksc_pkg::t_out_word              o_data,
    input  logic                             i_cfg_we,
    input  logic [lksc_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import lksc_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = $clog2(SLOTS + 1);
    localparam int PW    = $clog2(PREFIX_LEN + 1);
    localparam int DEPTH = SLOTS * PREFIX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_TOKEN  = 4'b0100,
        S_READ   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_in_word          r_item, n_item;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [CNT_W-1:0]  r_hits, n_hits, r_miss, n_miss, r_evict, n_evict;
    logic [PW-1:0]     r_pos, n_pos;
    logic [SW-1:0]     r_mslot, n_mslot;
    logic              r_fmatch, n_fmatch, r_fmis, n_fmis;
    logic              r_open, n_open, r_kzero, n_kzero;
    logic [1:0]        r_sop, n_sop;
    logic [NW-1:0]     r_cnt, n_cnt;
    logic [CFG_W-1:0]  r_cfg;
    logic [31:0]       r_rdata;
    logic [31:0]       mem [DEPTH];

    t_cell_ctl         ctl;
    logic [SW-1:0]     sel;
    logic [63:0]       wkey;
    logic [TICK_WIDTH-1:0] wtick;
    logic [PW-1:0]     wplen;
    logic              mem_we, mem_re;
    logic [AW-1:0]     addr;
    logic [8:0]        act9;
    logic [NW-1:0]     act;
    logic              do_emit, emit_found, finish;
    logic [SW-1:0]     emit_idx, victim;

    logic              c_hit [SLOTS+1];
    logic [SW-1:0]     c_hit_idx [SLOTS+1];
    logic              c_empty [SLOTS+1];
    logic [SW-1:0]     c_empty_idx [SLOTS+1];
    logic [TICK_WIDTH-1:0] c_best_tick [SLOTS+1];
    logic [SW-1:0]     c_best_idx [SLOTS+1];
    logic [PW-1:0]     c_plen [SLOTS];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb begin
        act9 = {4'b0, r_cfg};
        if (act9 == 9'd0) begin
            act9 = 9'd1;
        end
        if (act9 > 9'(SLOTS)) begin
            act9 = 9'(SLOTS);
        end
    end
    assign act = NW'(act9);

    assign c_hit[0]       = 1'b0;
    assign c_hit_idx[0]   = '0;
    assign c_empty[0]     = 1'b0;
    assign c_empty_idx[0] = '0;
    assign c_best_tick[0] = '1;
    assign c_best_idx[0]  = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lksc_cell #(
            .IDX(g), .SW(SW), .NW(NW), .PW(PW), .TICK_W(TICK_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_sel       (sel),
            .i_wkey      (wkey),
            .i_wtick     (wtick),
            .i_wplen     (wplen),
            .i_act       (act),
            .i_skey      (r_item.key),
            .i_hit       (c_hit[g]),
            .i_hit_idx   (c_hit_idx[g]),
            .i_empty     (c_empty[g]),
            .i_empty_idx (c_empty_idx[g]),
            .i_best_tick (c_best_tick[g]),
            .i_best_idx  (c_best_idx[g]),
            .o_hit       (c_hit[g+1]),
            .o_hit_idx   (c_hit_idx[g+1]),
            .o_empty     (c_empty[g+1]),
            .o_empty_idx (c_empty_idx[g+1]),
            .o_best_tick (c_best_tick[g+1]),
            .o_best_idx  (c_best_idx[g+1]),
            .o_plen      (c_plen[g])
        );
    end

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign addr    = AW'(AW'(r_mslot) * AW'(PREFIX_LEN) + AW'(r_pos));
    assign victim  = c_empty[SLOTS] ? c_empty_idx[SLOTS] : c_best_idx[SLOTS];

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_tick      = r_tick;
        n_hits      = r_hits;
        n_miss      = r_miss;
        n_evict     = r_evict;
        n_pos       = r_pos;
        n_mslot     = r_mslot;
        n_fmatch    = r_fmatch;
        n_fmis      = r_fmis;
        n_open      = r_open;
        n_kzero     = r_kzero;
        n_sop       = r_sop;
        n_cnt       = r_cnt;
        ctl         = '0;
        sel         = r_mslot;
        wkey        = '0;
        wtick       = '0;
        wplen       = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        do_emit     = 1'b0;
        emit_found  = 1'b0;
        emit_idx    = '0;
        finish      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_item = i_data;
                    unique case (i_data.op)
                        OP_CLEAR: begin
                            ctl.clear  = 1'b1;
                            n_tick     = '0;
                            n_hits     = '0;
                            n_miss     = '0;
                            n_evict    = '0;
                            n_open     = 1'b0;
                            n_sop      = '0;
                            n_kzero    = 1'b0;
                            n_pos      = '0;
                            n_mslot    = '0;
                            n_fmatch   = 1'b0;
                            n_fmis     = 1'b0;
                            do_emit    = 1'b1;
                            emit_found = 1'b1;
                        end
                        OP_CLAIM: begin
                            n_open   = 1'b0;
                            n_sop    = '0;
                            n_kzero  = 1'b0;
                            n_pos    = '0;
                            n_mslot  = '0;
                            n_fmatch = 1'b0;
                            n_fmis   = 1'b0;
                            n_cnt    = '0;
                            n_state  = S_SEARCH;
                        end
                        default: begin
                            n_state = S_TOKEN;
                            if (!r_open || r_sop != i_data.op) begin
                                n_open   = 1'b1;
                                n_sop    = i_data.op;
                                n_pos    = '0;
                                n_mslot  = '0;
                                n_fmatch = 1'b0;
                                n_fmis   = 1'b0;
                                n_kzero  = i_data.key == 64'd0;
                                if (i_data.key != 64'd0) begin
                                    if (i_data.op == OP_LOOKUP) begin
                                        n_cnt   = '0;
                                        n_state = S_SEARCH;
                                    end else if ({1'b0, i_data.slot} < act9) begin
                                        n_mslot     = SW'(i_data.slot);
                                        n_fmatch    = 1'b1;
                                        sel         = SW'(i_data.slot);
                                        ctl.wr_key  = 1'b1;
                                        ctl.wr_tick = 1'b1;
                                        ctl.wr_plen = 1'b1;
                                        wkey        = i_data.key;
                                        n_tick      = r_tick + 1'b1;
                                        wtick       = n_tick;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == NW'(SLOTS)) begin
                    if (r_item.op == OP_CLAIM) begin
                        if (!c_empty[SLOTS]) begin
                            n_evict = sat_inc(r_evict);
                        end
                        sel         = victim;
                        ctl.wr_key  = 1'b1;
                        ctl.wr_plen = 1'b1;
                        do_emit     = 1'b1;
                        emit_found  = 1'b1;
                        emit_idx    = victim;
                        n_state     = S_IDLE;
                    end else begin
                        if (c_hit[SLOTS]) begin
                            n_mslot  = c_hit_idx[SLOTS];
                            n_fmatch = 1'b1;
                        end
                        n_state = S_TOKEN;
                    end
                end
            end
            S_TOKEN: begin
                if (r_item.has_token && r_fmatch && r_pos < PW'(PREFIX_LEN)) begin
                    if (r_item.op == OP_LOOKUP) begin
                        mem_re  = 1'b1;
                        n_state = S_READ;
                    end else begin
                        mem_we      = 1'b1;
                        ctl.wr_plen = 1'b1;
                        wplen       = r_pos + 1'b1;
                        finish      = 1'b1;
                    end
                end else begin
                    finish = 1'b1;
                end
            end
            S_READ: begin
                if (r_pos < c_plen[r_mslot] && r_rdata != r_item.token) begin
                    n_fmis = 1'b1;
                end
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state = S_IDLE;
            if (r_item.has_token && r_pos < PW'(PREFIX_LEN)) begin
                n_pos = r_pos + 1'b1;
            end
            if (r_item.last) begin
                emit_idx = r_mslot;
                if (r_item.op == OP_LOOKUP) begin
                    if (r_kzero) begin
                        emit_found = 1'b0;
                    end else if (!r_fmatch) begin
                        n_miss = sat_inc(r_miss);
                    end else if (n_fmis) begin
                        sel        = r_mslot;
                        ctl.wr_key = 1'b1;
                        n_evict    = sat_inc(r_evict);
                        n_miss     = sat_inc(r_miss);
                    end else begin
                        sel         = r_mslot;
                        ctl.wr_tick = 1'b1;
                        n_tick      = r_tick + 1'b1;
                        wtick       = n_tick;
                        n_hits      = sat_inc(r_hits);
                        emit_found  = 1'b1;
                    end
                end else begin
                    emit_found = r_fmatch;
                end
                n_open   = 1'b0;
                n_sop    = '0;
                n_kzero  = 1'b0;
                n_pos    = '0;
                n_mslot  = '0;
                n_fmatch = 1'b0;
                n_fmis   = 1'b0;
                do_emit  = 1'b1;
            end
        end

        if (do_emit) begin
            n_out_valid          = 1'b1;
            n_out.found          = emit_found;
            n_out.slot_index     = emit_found ? 4'(emit_idx) : 4'd0;
            n_out.hit_count      = n_hits;
            n_out.miss_count     = n_miss;
            n_out.eviction_count = n_evict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= r_item.token;
        end
        if (mem_re) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_hits      <= '0;
            r_miss      <= '0;
            r_evict     <= '0;
            r_pos       <= '0;
            r_mslot     <= '0;
            r_fmatch    <= 1'b0;
            r_fmis      <= 1'b0;
            r_open      <= 1'b0;
            r_kzero     <= 1'b0;
            r_sop       <= '0;
            r_cnt       <= '0;
            r_cfg       <= CFG_W'(16);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tick      <= n_tick;
            r_hits      <= n_hits;
            r_miss      <= n_miss;
            r_evict     <= n_evict;
            r_pos       <= n_pos;
            r_mslot     <= n_mslot;
            r_fmatch    <= n_fmatch;
            r_fmis      <= n_fmis;
            r_open      <= n_open;
            r_kzero     <= n_kzero;
            r_sop       <= n_sop;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

endmodule

FILE: sv/lksc_cell.sv
// lksc_cell: one slot of the table (key, tick, prefix length) and one stage
// of the registered search chain; uses lksc_pkg
`timescale 1ns / 1ps
module lksc_cell #(
    parameter int IDX     = 0,
    parameter int SW      = 4,
    parameter int NW      = 5,
    parameter int PW      = 6,
    parameter int TICK_W  = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lksc_pkg::t_cell_ctl i_ctl,
    input  logic [SW-1:0]       i_sel,
    input  logic [63:0]         i_wkey,
    input  logic [TICK_W-1:0]   i_wtick,
    input  logic [PW-1:0]       i_wplen,
    input  logic [NW-1:0]       i_act,
    input  logic [63:0]         i_skey,
    input  logic                i_hit,
    input  logic [SW-1:0]       i_hit_idx,
    input  logic                i_empty,
    input  logic [SW-1:0]       i_empty_idx,
    input  logic [TICK_W-1:0]   i_best_tick,
    input  logic [SW-1:0]       i_best_idx,
    output logic                o_hit,
    output logic [SW-1:0]       o_hit_idx,
    output logic                o_empty,
    output logic [SW-1:0]       o_empty_idx,
    output logic [TICK_W-1:0]   o_best_tick,
    output logic [SW-1:0]       o_best_idx,
    output logic [PW-1:0]       o_plen
);
    import lksc_pkg::*;

    localparam logic [SW-1:0] MY_IDX = SW'(IDX);

    logic [63:0]       r_key;
    logic [TICK_W-1:0] r_tick;
    logic [PW-1:0]     r_plen;
    logic              active;
    logic              me;

    assign active = NW'(IDX) < i_act;
    assign me     = i_sel == MY_IDX;
    assign o_plen = r_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_key  <= '0;
            r_tick <= '0;
            r_plen <= '0;
        end else if (me) begin
            if (i_ctl.wr_key) begin
                r_key <= i_wkey;
            end
            if (i_ctl.wr_tick) begin
                r_tick <= i_wtick;
            end
            if (i_ctl.wr_plen) begin
                r_plen <= i_wplen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit       <= i_hit || (active && i_skey != 64'd0 && r_key == i_skey);
        o_hit_idx   <= i_hit ? i_hit_idx : MY_IDX;
        o_empty     <= i_empty || (active && r_key == 64'd0);
        o_empty_idx <= i_empty ? i_empty_idx : MY_IDX;
        if (active && r_tick < i_best_tick) begin
            o_best_tick <= r_tick;
            o_best_idx  <= MY_IDX;
        end else begin
            o_best_tick <= i_best_tick;
            o_best_idx  <= i_best_idx;
        end
    end

endmodule

FILE: sv/lksc_checker.sv
// lksc_checker: port level checks for lru_keyed_slot_cache, with its bind
// uses lksc_pkg
`timescale 1ns / 1ps
module lksc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input lksc_pkg::t_out_word        o_data
);
    import lksc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word dropped or changed while stalled");

    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.found |-> o_data.slot_index == 4'd0)
        else $error("slot index set without found");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in flight");

    a_no_ready_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

endmodule

bind lru_keyed_slot_cache lksc_checker u_lksc_checker (.*);

FILE: dv/tb_lru_keyed_slot_cache.sv
// tb_lru_keyed_slot_cache: self-checking bench for the keyed slot cache, with a
// behavioral model of the slot table in a small scoreboard class
// uses lksc_pkg and lru_keyed_slot_cache
`timescale 1ns / 1ps
module tb_lru_keyed_slot_cache;
    import lksc_pkg::*;

    localparam int NSLOT = 16;
    localparam int NPRE  = 32;
    localparam int WDOG  = 20000;

    class slot_table_sb;
        logic [63:0] key_q [NSLOT];
        logic [47:0] tick_q [NSLOT];
        int unsigned plen [NSLOT];
        logic [31:0] pmem [NSLOT*NPRE];
        logic [47:0] tick_ctr;
        logic [31:0] hits, misses, evicts;
        int unsigned pos, mslot;
        bit f_match, f_mismatch, open, kzero;
        logic [1:0] sop;
        int unsigned in_use;
        t_out_word pending [$];
        int errors;

        function new();
            in_use = 16;
            errors = 0;
            foreach (pmem[i]) pmem[i] = '0;
            clear_all();
        endfunction

        function void close_stream();
            open = 0; sop = OP_LOOKUP; kzero = 0; pos = 0; mslot = 0;
            f_match = 0; f_mismatch = 0;
        endfunction

        function void clear_all();
            foreach (key_q[i]) begin
                key_q[i] = '0; tick_q[i] = '0; plen[i] = 0;
            end
            tick_ctr = '0; hits = '0; misses = '0; evicts = '0;
            close_stream();
        endfunction

        function int unsigned active();
            if (in_use == 0) return 1;
            if (in_use > NSLOT) return NSLOT;
            return in_use;
        endfunction

        function logic [31:0] sat(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        function logic [47:0] bump_tick();
            tick_ctr = tick_ctr + 1;
            return tick_ctr;
        endfunction

        function void push(bit f, int unsigned idx);
            t_out_word w;
            w.found = f;
            w.slot_index = f ? idx[3:0] : 4'd0;
            w.hit_count = hits; w.miss_count = misses; w.eviction_count = evicts;
            pending.push_back(w);
        endfunction

        function void note_input(t_in_word w);
            int unsigned n, best;
            logic [47:0] bt;
            bit f;
            if (open && sop != w.op) close_stream();
            if (w.op == OP_CLEAR) begin
                clear_all(); push(1, 0); return;
            end
            if (w.op == OP_CLAIM) begin
                close_stream();
                n = active(); best = 0; bt = tick_q[0];
                for (int i = 0; i < n; i++) begin
                    if (key_q[i] == 0) begin best = i; break; end
                    if (tick_q[i] < bt) begin bt = tick_q[i]; best = i; end
                end
                if (key_q[best] != 0) evicts = sat(evicts);
                key_q[best] = '0; plen[best] = 0;
                push(1, best); return;
            end
            n = active();
            if (!open) begin
                open = 1; sop = w.op; pos = 0; mslot = 0; f_match = 0; f_mismatch = 0;
                kzero = (w.key == 0);
                if (w.op == OP_LOOKUP) begin
                    if (!kzero)
                        for (int i = 0; i < n; i++)
                            if (key_q[i] == w.key) begin
                                mslot = i; f_match = 1; break;
                            end
                end else if (!kzero && w.slot < n) begin
                    mslot = w.slot; f_match = 1;
                    key_q[mslot] = w.key; tick_q[mslot] = bump_tick(); plen[mslot] = 0;
                end
            end
            if (w.has_token && f_match && pos < NPRE) begin
                if (w.op == OP_LOOKUP) begin
                    if (pos < plen[mslot] && pmem[mslot*NPRE+pos] != w.token)
                        f_mismatch = 1;
                end else begin
                    pmem[mslot*NPRE+pos] = w.token; plen[mslot] = pos + 1;
                end
            end
            if (w.has_token && pos < NPRE) pos++;
            if (!w.last) return;
            f = 0; best = mslot;
            if (w.op == OP_LOOKUP) begin
                if (kzero) f = 0;
                else if (!f_match) misses = sat(misses);
                else if (f_mismatch) begin
                    key_q[best] = '0; evicts = sat(evicts); misses = sat(misses);
                end else begin
                    tick_q[best] = bump_tick(); hits = sat(hits); f = 1;
                end
            end else f = f_match;
            close_stream();
            push(f, best);
        endfunction

        function void check_result(t_out_word a);
            t_out_word e;
            if (pending.size() == 0) begin
                $error("unexpected word %h", a); errors++; return;
            end
            e = pending.pop_front();
            if (a.found !== e.found) begin
                $error("found exp %0d got %0d", e.found, a.found); errors++;
            end
            if (a.slot_index !== e.slot_index) begin
                $error("slot_index exp %0d got %0d", e.slot_index, a.slot_index); errors++;
            end
            if (a.hit_count !== e.hit_count) begin
                $error("hit_count exp %0d got %0d", e.hit_count, a.hit_count); errors++;
            end
            if (a.miss_count !== e.miss_count) begin
                $error("miss_count exp %0d got %0d", e.miss_count, a.miss_count); errors++;
            end
            if (a.eviction_count !== e.eviction_count) begin
                $error("eviction_count exp %0d got %0d", e.eviction_count,
                       a.eviction_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    t_in_word i_data;
    t_out_word o_data;

    lru_keyed_slot_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    slot_table_sb sb = new();
    int idle_cycles = 0;
    int stall_mode = 0;
    int burst_left = 0;
    int sent_cnt = 0;
    logic [63:0] keys [8];

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_cfg_we = 1'b0;
        i_cfg_wdata = '0; i_data = '0;
    end

    // receiver stall pattern and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_data);
            if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(3) != 0);
                default: i_ready <= ($urandom_range(3) == 0);
            endcase
            if ($urandom_range(199) == 0) stall_mode <= $urandom_range(2);
        end
    end

    always @(posedge i_clk)
        if (idle_cycles > WDOG) begin
            $display("lru_keyed_slot_cache test failed");
            $finish;
        end

    task automatic send(input t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(w);
        sent_cnt++;
        burst_left--;
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [63:0] key,
                           input logic [7:0] slot, input logic [31:0] tok,
                           input bit has, input bit lst);
        t_in_word w;
        w.op = op; w.key = key; w.slot = slot; w.token = tok;
        w.has_token = has; w.last = lst;
        send(w);
    endtask

    task automatic drain();
        if (burst_left != 0) begin
            burst_left = 0;
            i_valid <= 1'b0;
        end
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 6) @(posedge i_clk);
    endtask

    task automatic set_slots(input int v);
        drain();
        i_cfg_we <= 1'b1; i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.in_use = v[CFG_W-1:0];
    endtask

    task automatic stream(input logic [1:0] op, input logic [63:0] key,
                          input logic [7:0] slot, input int ntok, input int base_k,
                          input bit corrupt);
        logic [31:0] t;
        if (ntok == 0) begin
            send_op(op, key, slot, $urandom, 0, 1);
            return;
        end
        for (int i = 0; i < ntok; i++) begin
            t = key[31:0] ^ (i * 32'h9E37_79B9) ^ base_k;
            if (corrupt && i == ntok - 1) t = ~t;
            send_op(op, key, slot, t, ($urandom_range(7) != 0) || !corrupt,
                    i == ntok - 1);
        end
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int r, k, n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (keys[i]) keys[i] = rand_key();
        keys[0] = '1;

        // directed: field extremes and special cases
        stream(OP_REGISTER, keys[0], 0, 3, 0, 0);
        stream(OP_LOOKUP, keys[0], 0, 3, 0, 0);
        stream(OP_LOOKUP, keys[0], 0, 3, 0, 1);
        stream(OP_LOOKUP, 64'd0, 8'hFF, 1, 0, 0);
        stream(OP_LOOKUP, 64'd5, 0, 0, 0, 0);
        stream(OP_REGISTER, 64'd0, 1, 1, 0, 0);
        stream(OP_REGISTER, keys[1], 8'hFF, 1, 0, 0);
        stream(OP_REGISTER, keys[2], 15, 34, 0, 0);
        stream(OP_LOOKUP, keys[2], 0, 34, 0, 0);
        send_op(OP_REGISTER, keys[3], 3, 32'h8000_0000, 1, 0);
        send_op(OP_LOOKUP, keys[3], 0, 32'h7FFF_FFFF, 1, 1);
        send_op(OP_CLAIM, 0, 0, 0, 0, 1);
        send_op(OP_CLAIM, 0, 0, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);
        set_slots(0);
        send_op(OP_CLAIM, 0, 0, 0, 0, 1);
        set_slots(31);
        send_op(OP_CLAIM, 0, 0, 0, 0, 1);
        set_slots(1);
        stream(OP_REGISTER, keys[4], 1, 1, 0, 0);
        stream(OP_REGISTER, keys[4], 0, 1, 0, 0);
        send_op(OP_CLAIM, 0, 0, 0, 0, 1);

        // random: mostly well-formed register and lookup streams on a small key set
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_slots(16);
                1: set_slots(4);
                2: set_slots($urandom_range(1, 16));
                3: set_slots(17);
                4: set_slots(2);
                default: set_slots(16);
            endcase
            if (ph == 3) drain();
            n = sent_cnt;
            while (sent_cnt - n < 245) begin
                r = $urandom_range(99);
                k = $urandom_range(7);
                if (r < 30) begin
                    stream(OP_REGISTER, keys[k], 8'($urandom_range(17)),
                           $urandom_range(0, 6), 0, 0);
                end else if (r < 70) begin
                    stream(OP_LOOKUP, ($urandom_range(9) == 0) ? rand_key() : keys[k], 0,
                           $urandom_range(0, 6), 0, $urandom_range(4) == 0);
                end else if (r < 82) begin
                    send_op(OP_CLAIM, rand_key(), 8'($urandom), $urandom, 1'($urandom),
                            1'($urandom));
                end else if (r < 85) begin
                    send_op(OP_CLEAR, rand_key(), 8'($urandom), $urandom, 1'($urandom),
                            1'($urandom));
                end else begin
                    send_op($urandom_range(3) == 0 ? OP_REGISTER : OP_LOOKUP,
                            ($urandom_range(5) == 0) ? 64'd0 : rand_key(), 8'($urandom),
                            $urandom, 1'($urandom), 0);
                end
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lru_keyed_slot_cache test passed");
        else
            $display("lru_keyed_slot_cache test failed");
        $finish;
    end
endmodule
